// File: hdl/dda_pkg.sv
// Shared types and constants of the DDA line rasterizer.
// Used by every module of the block but dda_fifo; depends on nothing.
`default_nettype none

package dda_pkg;

   // default fraction bits of the position and increment registers
   localparam int FRAC_BITS_DEF = 16;

   // endpoint coordinates: signed Q12.8
   localparam int COORD_W = 21;
   localparam int IN_FRAC = 8;
   // endpoint difference, one bit wider than a coordinate
   localparam int DIFF_W  = COORD_W + 1;
   // step count n-1
   localparam int STEP_W  = 14;
   // integer bits of a position register (position width is FRAC_BITS + this)
   localparam int CUR_INT_W = 16;
   // emitted pixel coordinates
   localparam int PIX_W   = 14;
   localparam int PIX_MAX = (1 << (PIX_W - 1)) - 1;

   // configuration register widths
   localparam int SCR_W   = 12;
   localparam int PAN_W   = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   // clip window in whole pixels
   localparam int CLIP_HI_PIX = 1100;
   localparam int CLIP_LO_PIX = -800;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_PAN_X         = 2'd2,
      CSR_PAN_Y         = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        [SCR_W-1:0] screen_width;
      logic        [SCR_W-1:0] screen_height;
      logic signed [PAN_W-1:0] pan_x;
      logic signed [PAN_W-1:0] pan_y;
   } cfg_type;

   // command classes produced by the front
   typedef enum logic [1:0] {
      CMD_ADVANCE = 2'd0,
      CMD_POINT   = 2'd1,
      CMD_LINE    = 2'd2
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_DIV  = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

// File: hdl/dda_fifo.sv
// Small flip-flop queue between the front classifier and the back engine.
// Generic width and depth; no package dependency.
`default_nettype none

module dda_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/dda_div.sv
// Restoring divider for one axis increment: round(diff * 2^(F-8) / d), half away from zero.
// One quotient bit per cycle; uses widths from dda_pkg.
`default_nettype none

module dda_div #(
   parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        start,
   input  wire logic signed [dda_pkg::DIFF_W-1:0]           diff,
   input  wire logic        [dda_pkg::STEP_W-1:0]           divisor,
   output logic                                             done,
   output logic signed [dda_pkg::DIFF_W+FRAC_BITS-dda_pkg::IN_FRAC-1:0] quotient
);

   // magnitude of the scaled numerator, dividend 2*mag + d, divisor 2*d
   localparam int MAG_W = dda_pkg::DIFF_W - 1 + FRAC_BITS - dda_pkg::IN_FRAC;
   localparam int NW    = MAG_W + 2;
   localparam int DSR_W = dda_pkg::STEP_W + 1;
   localparam int CNT_W = $clog2(NW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff,  neg_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [NW-1:0]    dvd_ff,  dvd_in;
   logic [DSR_W-1:0] rem_ff,  rem_in;
   logic [DSR_W-1:0] dsr_ff,  dsr_in;

   logic [dda_pkg::DIFF_W-1:0] diff_mag;
   logic [MAG_W-1:0]           num_mag;
   logic [DSR_W:0]             trial;
   logic                       q_bit;
   logic [MAG_W:0]             q_ext;

   // operand set-up and one restoring step
   always_comb begin
      diff_mag = diff[dda_pkg::DIFF_W-1] ? dda_pkg::DIFF_W'(-diff)
                                         : dda_pkg::DIFF_W'(diff);
      num_mag  = MAG_W'(diff_mag[dda_pkg::DIFF_W-2:0]) << (FRAC_BITS - dda_pkg::IN_FRAC);
      trial    = {rem_ff, dvd_ff[NW-1]};
      q_bit    = (trial >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = diff[dda_pkg::DIFF_W-1];
         cnt_in  = CNT_W'(NW - 1);
         dvd_in  = {1'b0, num_mag, 1'b0} + NW'(divisor);
         rem_in  = '0;
         dsr_in  = {divisor, 1'b0};
      end else if (busy_ff) begin
         rem_in = q_bit ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         dvd_in = {dvd_ff[NW-2:0], q_bit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   // quotient never exceeds the numerator magnitude
   assign q_ext    = {1'b0, dvd_ff[MAG_W-1:0]};
   assign quotient = neg_ff ? -signed'(q_ext) : signed'(q_ext);
   assign done     = done_ff;

endmodule

`default_nettype wire

// File: hdl/dda_front.sv
// Front classifier: rounds endpoints, finds the step count and the offset start point.
// Combinational; uses dda_pkg types and constants.
`default_nettype none

module dda_front #(
   parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                    mode,
   input  wire logic signed [dda_pkg::COORD_W-1:0]      start_x,
   input  wire logic signed [dda_pkg::COORD_W-1:0]      start_y,
   input  wire logic signed [dda_pkg::COORD_W-1:0]      end_x,
   input  wire logic signed [dda_pkg::COORD_W-1:0]      end_y,
   input  wire dda_pkg::cfg_type                        cfg,
   output dda_pkg::cmd_kind_type                        kind,
   output logic signed [FRAC_BITS+dda_pkg::CUR_INT_W-1:0] pos_x,
   output logic signed [FRAC_BITS+dda_pkg::CUR_INT_W-1:0] pos_y,
   output logic signed [dda_pkg::DIFF_W-1:0]            diff_x,
   output logic signed [dda_pkg::DIFF_W-1:0]            diff_y,
   output logic        [dda_pkg::STEP_W-1:0]            steps
);

   localparam int CUR_W = FRAC_BITS + dda_pkg::CUR_INT_W;
   localparam int RND_W = dda_pkg::COORD_W - dda_pkg::IN_FRAC + 2;

   // Q12.8 to whole pixels, half away from zero
   function automatic logic signed [RND_W-1:0] round_pix(
      input logic signed [dda_pkg::COORD_W-1:0] v
   );
      logic [dda_pkg::COORD_W-1:0] mag;
      logic [dda_pkg::COORD_W:0]   sum;
      logic [RND_W-1:0]            r;
      mag = v[dda_pkg::COORD_W-1] ? dda_pkg::COORD_W'(-v) : dda_pkg::COORD_W'(v);
      sum = {1'b0, mag} + ((dda_pkg::COORD_W + 1)'(1) << (dda_pkg::IN_FRAC - 1));
      r   = RND_W'(sum >> dda_pkg::IN_FRAC);
      round_pix = v[dda_pkg::COORD_W-1] ? -signed'(r) : signed'(r);
   endfunction

   logic signed [RND_W-1:0]   dx_s, dy_s;
   logic        [RND_W-1:0]   dx_a, dy_a;
   logic [dda_pkg::STEP_W-1:0] dx, dy;

   // step count on rounded endpoints
   always_comb begin
      dx_s  = round_pix(start_x) - round_pix(end_x);
      dy_s  = round_pix(start_y) - round_pix(end_y);
      dx_a  = dx_s[RND_W-1] ? RND_W'(-dx_s) : RND_W'(dx_s);
      dy_a  = dy_s[RND_W-1] ? RND_W'(-dy_s) : RND_W'(dy_s);
      dx    = dx_a[dda_pkg::STEP_W-1:0];
      dy    = dy_a[dda_pkg::STEP_W-1:0];
      steps = (dx > dy) ? dx : dy;
   end

   // classification
   always_comb begin
      if (mode) begin
         kind = dda_pkg::CMD_ADVANCE;
      end else if (steps == '0) begin
         kind = dda_pkg::CMD_POINT;
      end else begin
         kind = dda_pkg::CMD_LINE;
      end
   end

   // unrounded differences and offset start point
   assign diff_x = dda_pkg::DIFF_W'(end_x) - dda_pkg::DIFF_W'(start_x);
   assign diff_y = dda_pkg::DIFF_W'(end_y) - dda_pkg::DIFF_W'(start_y);

   assign pos_x = (CUR_W'(start_x) <<< (FRAC_BITS - dda_pkg::IN_FRAC))
                + (CUR_W'({1'b0, cfg.screen_width[dda_pkg::SCR_W-1:1]}) << FRAC_BITS)
                + (CUR_W'(cfg.pan_x) <<< FRAC_BITS);
   assign pos_y = (CUR_W'(start_y) <<< (FRAC_BITS - dda_pkg::IN_FRAC))
                + (CUR_W'({1'b0, cfg.screen_height[dda_pkg::SCR_W-1:1]}) << FRAC_BITS)
                + (CUR_W'(cfg.pan_y) <<< FRAC_BITS);

endmodule

`default_nettype wire

// File: hdl/dda_back.sv
// Back engine: runs queued commands, holds the line state, steps and clips, drives results.
// Instantiates dda_div twice; uses dda_pkg types and constants.
`default_nettype none

module dda_back #(
   parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        head_valid,
   input  wire dda_pkg::cmd_kind_type                       hd_kind,
   input  wire logic signed [FRAC_BITS+dda_pkg::CUR_INT_W-1:0] hd_px,
   input  wire logic signed [FRAC_BITS+dda_pkg::CUR_INT_W-1:0] hd_py,
   input  wire logic signed [dda_pkg::DIFF_W-1:0]           hd_diff_x,
   input  wire logic signed [dda_pkg::DIFF_W-1:0]           hd_diff_y,
   input  wire logic        [dda_pkg::STEP_W-1:0]           hd_steps,
   output logic                                             pop,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_ready,
   output logic signed [dda_pkg::PIX_W-1:0]                 rsp_point_x,
   output logic signed [dda_pkg::PIX_W-1:0]                 rsp_point_y,
   output logic                                             rsp_status,
   output logic                                             rsp_last
);

   localparam int CUR_W  = FRAC_BITS + dda_pkg::CUR_INT_W;
   localparam int INC_W  = dda_pkg::DIFF_W + FRAC_BITS - dda_pkg::IN_FRAC;
   localparam int PIXR_W = CUR_W - FRAC_BITS;
   localparam logic signed [CUR_W-1:0] CLIP_HI = CUR_W'(dda_pkg::CLIP_HI_PIX) << FRAC_BITS;
   localparam logic signed [CUR_W-1:0] CLIP_LO = CUR_W'(dda_pkg::CLIP_LO_PIX) << FRAC_BITS;

   // position to pixel, half away from zero, saturated to the pixel range
   function automatic logic [dda_pkg::PIX_W-1:0] to_pix(input logic signed [CUR_W-1:0] v);
      logic [CUR_W-1:0]  mag;
      logic [CUR_W-1:0]  sum;
      logic [PIXR_W-1:0] r;
      logic [dda_pkg::PIX_W-1:0] res;
      mag = v[CUR_W-1] ? CUR_W'(-v) : CUR_W'(v);
      sum = mag + (CUR_W'(1) << (FRAC_BITS - 1));
      r   = sum[CUR_W-1:FRAC_BITS];
      if (v[CUR_W-1]) begin
         if (r > PIXR_W'(dda_pkg::PIX_MAX + 1)) begin
            res = dda_pkg::PIX_W'(dda_pkg::PIX_MAX + 1);
         end else begin
            res = dda_pkg::PIX_W'(-r);
         end
      end else begin
         if (r > PIXR_W'(dda_pkg::PIX_MAX)) begin
            res = dda_pkg::PIX_W'(dda_pkg::PIX_MAX);
         end else begin
            res = dda_pkg::PIX_W'(r);
         end
      end
      to_pix = res;
   endfunction

   dda_pkg::back_state_type state_ff, state_in;

   logic                       line_active_ff, line_active_in;
   logic [dda_pkg::STEP_W-1:0] steps_ff,       steps_in;
   logic signed [CUR_W-1:0]    cur_x_ff,       cur_x_in;
   logic signed [CUR_W-1:0]    cur_y_ff,       cur_y_in;
   logic signed [INC_W-1:0]    inc_x_ff,       inc_x_in;
   logic signed [INC_W-1:0]    inc_y_ff,       inc_y_in;

   logic                              rsp_valid_ff,  rsp_valid_in;
   logic signed [dda_pkg::PIX_W-1:0]  point_x_ff,    point_x_in;
   logic signed [dda_pkg::PIX_W-1:0]  point_y_ff,    point_y_in;
   logic                              status_ff,     status_in;
   logic                              last_ff,       last_in;

   logic                    out_free;
   logic                    emit;
   logic                    div_start;
   logic                    done_x, done_y, div_done;
   logic signed [INC_W-1:0] q_x, q_y;
   logic signed [CUR_W-1:0] sum_x, sum_y, src_x, src_y;
   logic                    clip;
   logic                    clip_hit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign div_done = done_x && done_y;

   // increment dividers, one per axis, started together
   dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .diff     (hd_diff_x),
      .divisor  (hd_steps),
      .done     (done_x),
      .quotient (q_x)
   );

   dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .diff     (hd_diff_y),
      .divisor  (hd_steps),
      .done     (done_y),
      .quotient (q_y)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dda_pkg::BK_IDLE: begin
            if (head_valid && (hd_kind == dda_pkg::CMD_LINE)) begin
               state_in = dda_pkg::BK_DIV;
            end
         end
         dda_pkg::BK_DIV: begin
            if (div_done) begin
               state_in = dda_pkg::BK_IDLE;
            end
         end
         default: state_in = dda_pkg::BK_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      pop       = 1'b0;
      div_start = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         dda_pkg::BK_IDLE: begin
            if (head_valid) begin
               case (hd_kind)
                  dda_pkg::CMD_LINE: begin
                     pop       = 1'b1;
                     div_start = 1'b1;
                  end
                  dda_pkg::CMD_POINT: begin
                     pop  = out_free;
                     emit = out_free;
                  end
                  dda_pkg::CMD_ADVANCE: begin
                     pop  = out_free;
                     emit = out_free && line_active_ff;
                  end
                  default: ;
               endcase
            end
         end
         dda_pkg::BK_DIV: ;
         default: ;
      endcase
   end

   // step, clip test and source select
   always_comb begin
      sum_x    = cur_x_ff + CUR_W'(inc_x_ff);
      sum_y    = cur_y_ff + CUR_W'(inc_y_ff);
      clip     = (sum_x > CLIP_HI) || (sum_y > CLIP_HI) ||
                 (sum_x < CLIP_LO) || (sum_y < CLIP_LO);
      clip_hit = (hd_kind == dda_pkg::CMD_ADVANCE) && clip;
      src_x    = (hd_kind == dda_pkg::CMD_POINT) ? hd_px : sum_x;
      src_y    = (hd_kind == dda_pkg::CMD_POINT) ? hd_py : sum_y;
   end

   // line state update
   always_comb begin
      line_active_in = line_active_ff;
      steps_in       = steps_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      inc_x_in       = inc_x_ff;
      inc_y_in       = inc_y_ff;
      if (div_done) begin
         inc_x_in       = q_x;
         inc_y_in       = q_y;
         line_active_in = 1'b1;
      end
      if (pop) begin
         case (hd_kind)
            dda_pkg::CMD_LINE: begin
               cur_x_in       = hd_px;
               cur_y_in       = hd_py;
               steps_in       = hd_steps;
               line_active_in = 1'b0;
            end
            dda_pkg::CMD_POINT: begin
               steps_in       = '0;
               line_active_in = 1'b0;
            end
            dda_pkg::CMD_ADVANCE: begin
               if (line_active_ff) begin
                  cur_x_in = sum_x;
                  cur_y_in = sum_y;
                  if (clip) begin
                     steps_in       = '0;
                     line_active_in = 1'b0;
                  end else begin
                     steps_in       = steps_ff - 1'b1;
                     line_active_in = (steps_ff != dda_pkg::STEP_W'(1));
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      point_x_in   = point_x_ff;
      point_y_in   = point_y_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         point_x_in   = clip_hit ? '0 : signed'(to_pix(src_x));
         point_y_in   = clip_hit ? '0 : signed'(to_pix(src_y));
         status_in    = clip_hit;
         last_in      = (hd_kind == dda_pkg::CMD_POINT) || clip_hit ||
                        (steps_ff == dda_pkg::STEP_W'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dda_pkg::BK_IDLE;
         line_active_ff <= 1'b0;
         steps_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         steps_ff       <= steps_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      inc_x_ff   <= inc_x_in;
      inc_y_ff   <= inc_y_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = point_x_ff;
   assign rsp_point_y = point_y_ff;
   assign rsp_status  = status_ff;
   assign rsp_last    = last_ff;

   // checks
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == dda_pkg::BK_DIV))
      else $error("divider finished outside the divide state");

   a_div_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      done_x == done_y)
      else $error("axis dividers out of step");

   a_active_has_steps: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (steps_ff != '0))
      else $error("active line with no steps left");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten before it was taken");

   a_div_line_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dda_pkg::BK_DIV) |-> !line_active_ff)
      else $error("line active while increments are being divided");

endmodule

`default_nettype wire

// File: hdl/dda_line_rasterizer_core.sv
// DDA line rasterizer, top level. Begin transactions with n = 1 give their point through
// the queue and the result register; begin with n > 1 holds the back engine during the
// serial increment divide. Advance transactions then give one point per cycle while
// results are taken (rsp_ready); a 2-entry queue decouples input.
// Synchronous active-high reset clears control state and configuration; no clearing pass.
// Depends on dda_pkg, dda_front, dda_fifo, dda_back.
`default_nettype none

module dda_line_rasterizer_core #(
   parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic                                     req_mode,
   input  wire logic signed [dda_pkg::COORD_W-1:0]       req_start_x,
   input  wire logic signed [dda_pkg::COORD_W-1:0]       req_start_y,
   input  wire logic signed [dda_pkg::COORD_W-1:0]       req_end_x,
   input  wire logic signed [dda_pkg::COORD_W-1:0]       req_end_y,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic signed [dda_pkg::PIX_W-1:0]              rsp_point_x,
   output logic signed [dda_pkg::PIX_W-1:0]              rsp_point_y,
   output logic                                          rsp_status,
   output logic                                          rsp_last,
   input  wire logic                                     csr_we,
   input  wire logic [dda_pkg::CSR_IDX_W-1:0]            csr_index,
   input  wire logic [dda_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   localparam int CUR_W   = FRAC_BITS + dda_pkg::CUR_INT_W;
   localparam int KIND_W  = $bits(dda_pkg::cmd_kind_type);
   localparam int ENTRY_W = KIND_W + 2 * CUR_W + 2 * dda_pkg::DIFF_W + dda_pkg::STEP_W;

   dda_pkg::cfg_type cfg_ff, cfg_in;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (dda_pkg::csr_index_type'(csr_index))
            dda_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[dda_pkg::SCR_W-1:0];
            dda_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[dda_pkg::SCR_W-1:0];
            dda_pkg::CSR_PAN_X:         cfg_in.pan_x = signed'(csr_wdata[dda_pkg::PAN_W-1:0]);
            dda_pkg::CSR_PAN_Y:         cfg_in.pan_y = signed'(csr_wdata[dda_pkg::PAN_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front classifier
   dda_pkg::cmd_kind_type      fr_kind;
   logic signed [CUR_W-1:0]    fr_px, fr_py;
   logic signed [dda_pkg::DIFF_W-1:0] fr_diff_x, fr_diff_y;
   logic [dda_pkg::STEP_W-1:0] fr_steps;

   dda_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .mode    (req_mode),
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .cfg     (cfg_ff),
      .kind    (fr_kind),
      .pos_x   (fr_px),
      .pos_y   (fr_py),
      .diff_x  (fr_diff_x),
      .diff_y  (fr_diff_y),
      .steps   (fr_steps)
   );

   // command queue
   logic               q_full, q_push, q_pop, q_valid;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   dda_pkg::cmd_kind_type      hd_kind;
   logic [KIND_W-1:0]          hd_kind_bits;
   logic signed [CUR_W-1:0]    hd_px, hd_py;
   logic signed [dda_pkg::DIFF_W-1:0] hd_diff_x, hd_diff_y;
   logic [dda_pkg::STEP_W-1:0] hd_steps;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_wdata   = {fr_kind, fr_px, fr_py, fr_diff_x, fr_diff_y, fr_steps};
   assign {hd_kind_bits, hd_px, hd_py, hd_diff_x, hd_diff_y, hd_steps} = q_rdata;
   assign hd_kind   = dda_pkg::cmd_kind_type'(hd_kind_bits);

   dda_fifo #(.WIDTH(ENTRY_W), .DEPTH(dda_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_rdata)
   );

   // back engine
   dda_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_valid),
      .hd_kind     (hd_kind),
      .hd_px       (hd_px),
      .hd_py       (hd_py),
      .hd_diff_x   (hd_diff_x),
      .hd_diff_y   (hd_diff_y),
      .hd_steps    (hd_steps),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire
